FILE: design/tfep_pkg.sv
package tfep_pkg;

  // Fixed field widths of the command and result items
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CX_W    = 9;
  localparam int unsigned CY_W    = 8;
  localparam int unsigned AXIS_W  = 9;
  localparam int unsigned COLOR_W = 8;

  // Width of the Bresenham decision terms (a2s, b2s, delta)
  localparam int unsigned DW = 36;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CRATER  = 2'd0;
  localparam logic [OP_W-1:0] OP_ELLIPSE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  localparam logic [COLOR_W-1:0] CLEAR_COLOR = 8'hFF;
  localparam logic [COLOR_W-1:0] EDGE_OFFSET = 8'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CX_W-1:0]    center_x;
    logic [CY_W-1:0]    center_y;
    logic [AXIS_W-1:0]  vertical_axis;
    logic [AXIS_W-1:0]  horizontal_axis;
    logic [COLOR_W-1:0] paint_color;
  } tfep_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               drew_shape;
  } tfep_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_READ,
    ST_RDATA,
    ST_CENTER,
    ST_MUL1,
    ST_MUL2,
    ST_SPAN,
    ST_EDGE,
    ST_STEP
  } tfep_state_e;

endpackage

FILE: design/tfep_ram.sv
module tfep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/toroidal_filled_ellipse_painter_core.sv
// Channel  | Dir | Handshake                          | Payload
// command  | in  | transfer when start && !busy       | item_i   (tfep_in_t)
// result   | out | transfer when done_o (one cycle)   | result_o (tfep_out_t)
//
// Reset runs a clearing pass over all 2*GRID_HEIGHT*GRID_HEIGHT pixels (131072 by default)
// that sets every pixel to 255 with busy high. An unused op code returns in the next cycle.
// Other items wrap first, one modulo step per cycle, until the center and both end rows lie
// on the grid. A read reads the RAM in ST_READ/ST_RDATA. A shape writes a small crater's
// center, squares the axes (ST_MUL1, ST_MUL2), writes 2*(2*xi+1) pixels per new row, 4 per
// point on the same row. The result strobes with busy low and cannot be stalled.
module toroidal_filled_ellipse_painter_core #(
  parameter int unsigned GRID_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  tfep_pkg::tfep_in_t  item_i,
  output logic                busy,
  output logic                done_o,
  output tfep_pkg::tfep_out_t result_o
);
  import tfep_pkg::*;

  localparam int unsigned GRID_WIDTH = 2 * GRID_HEIGHT;
  localparam int unsigned DEPTH      = GRID_HEIGHT * GRID_WIDTH;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned XW         = $clog2(GRID_WIDTH);
  localparam int unsigned YW         = $clog2(GRID_HEIGHT);
  localparam int unsigned RW         = (XW > 10) ? XW + 2 : 12;
  localparam int unsigned XIW        = AXIS_W + 1;
  localparam int unsigned CNTW       = XIW + 1;
  localparam int unsigned SQW        = 2 * AXIS_W;

  localparam logic signed [RW-1:0] MOD_X = RW'(GRID_WIDTH);
  localparam logic signed [RW-1:0] MOD_Y = RW'(GRID_HEIGHT);

  function automatic logic signed [RW-1:0] wrap_step(logic signed [RW-1:0] v,
                                                     logic signed [RW-1:0] m);
    logic signed [RW-1:0] r;
    if (v[RW-1]) begin
      r = v + m;
    end else if (v >= m) begin
      r = v - m;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic in_range(logic signed [RW-1:0] v, logic signed [RW-1:0] m);
    return !v[RW-1] && (v < m);
  endfunction

  function automatic logic [XW-1:0] inc_x(logic [XW-1:0] v);
    return (v == XW'(GRID_WIDTH - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [XW-1:0] dec_x(logic [XW-1:0] v);
    return (v == '0) ? XW'(GRID_WIDTH - 1) : v - 1'b1;
  endfunction

  function automatic logic [YW-1:0] inc_y(logic [YW-1:0] v);
    return (v == YW'(GRID_HEIGHT - 1)) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [YW-1:0] dec_y(logic [YW-1:0] v);
    return (v == '0) ? YW'(GRID_HEIGHT - 1) : v - 1'b1;
  endfunction

  tfep_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic done_q, done_d;
  tfep_out_t res_q, res_d;

  tfep_in_t item_q, item_d;
  logic signed [RW-1:0] rx_q, rx_d, ry_q, ry_d, rp_q, rp_d, rm_q, rm_d;
  logic [XW-1:0] xp_q, xp_d, xm_q, xm_d, sx_q, sx_d;
  logic [YW-1:0] yp_q, yp_d, ym_q, ym_d;
  logic [XIW-1:0] xi_q, xi_d;
  logic signed [XIW:0] yi_q, yi_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic phase_q, phase_d;
  logic [1:0] ecnt_q, ecnt_d;
  logic [SQW-1:0] a2_q, a2_d, b2_q, b2_d;
  logic signed [DW-1:0] a2s_q, a2s_d, b2s_q, b2s_d, delta_q, delta_d;

  // RAM port
  logic mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;

  // Walk decision terms
  logic [AXIS_W-1:0] aa, bb;
  logic [SQW+XIW-1:0] b2s_init;
  logic signed [DW-1:0] two_delta, a2s_inc, b2s_dec, sum_b, diff_a;
  logic step_diag, step_horiz, xinc, ydec;
  logic [COLOR_W-1:0] edge_color;

  assign aa = item_q.vertical_axis;
  assign bb = (item_q.op == OP_CRATER) ? item_q.vertical_axis : item_q.horizontal_axis;
  assign edge_color = item_q.paint_color + EDGE_OFFSET;

  assign b2s_init  = b2_q * (SQW + XIW)'({aa, 1'b1});
  assign two_delta = delta_q <<< 1;
  assign a2s_inc   = a2s_q + (DW'(a2_q) <<< 1);
  assign b2s_dec   = b2s_q - (DW'(b2_q) <<< 1);
  assign sum_b     = two_delta + b2s_q;
  assign diff_a    = two_delta - a2s_q;

  always_comb begin
    step_diag  = 1'b0;
    step_horiz = 1'b0;
    if (delta_q[DW-1]) begin
      if (!sum_b[DW-1] && (sum_b != '0)) begin
        step_diag = 1'b1;
      end else begin
        step_horiz = 1'b1;
      end
    end else if ((delta_q == '0) || diff_a[DW-1] || (diff_a == '0)) begin
      step_diag = 1'b1;
    end
  end

  assign xinc = step_diag || step_horiz;
  assign ydec = !step_horiz;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    done_d  = 1'b0;
    res_d   = res_q;
    item_d  = item_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    rp_d    = rp_q;
    rm_d    = rm_q;
    xp_d    = xp_q;
    xm_d    = xm_q;
    sx_d    = sx_q;
    yp_d    = yp_q;
    ym_d    = ym_q;
    xi_d    = xi_q;
    yi_d    = yi_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    ecnt_d  = ecnt_q;
    a2_d    = a2_q;
    b2_d    = b2_q;
    a2s_d   = a2s_q;
    b2s_d   = b2s_q;
    delta_d = delta_q;

    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = item_q.paint_color;
    ax        = rx_q[XW-1:0];
    ay        = ry_q[YW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = CLEAR_COLOR;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          item_d = item_i;
          rx_d   = RW'(item_i.center_x);
          ry_d   = RW'(item_i.center_y);
          rp_d   = RW'(item_i.center_y) + RW'(item_i.vertical_axis);
          rm_d   = RW'(item_i.center_y) - RW'(item_i.vertical_axis);
          if (item_i.op == OP_CRATER || item_i.op == OP_ELLIPSE || item_i.op == OP_READ) begin
            state_d = ST_WRAP;
          end else begin
            // unused code: empty result, no drawing
            done_d = 1'b1;
            res_d  = '0;
          end
        end
      end

      ST_WRAP: begin
        if (in_range(rx_q, MOD_X) && in_range(ry_q, MOD_Y) &&
            in_range(rp_q, MOD_Y) && in_range(rm_q, MOD_Y)) begin
          if (item_q.op == OP_READ) begin
            state_d = ST_READ;
          end else if (item_q.op == OP_CRATER && aa <= AXIS_W'(1)) begin
            state_d = ST_CENTER;
          end else if (aa == '0 || bb == '0) begin
            done_d  = 1'b1;
            res_d   = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MUL1;
          end
        end else begin
          rx_d = wrap_step(rx_q, MOD_X);
          ry_d = wrap_step(ry_q, MOD_Y);
          rp_d = wrap_step(rp_q, MOD_Y);
          rm_d = wrap_step(rm_q, MOD_Y);
        end
      end

      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_RDATA;
      end

      ST_RDATA: begin
        done_d            = 1'b1;
        res_d.pixel_value = mem_rdata;
        res_d.drew_shape  = 1'b0;
        state_d           = ST_IDLE;
      end

      ST_CENTER: begin
        mem_we = 1'b1;
        if (aa == '0) begin
          done_d  = 1'b1;
          res_d   = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MUL1;
        end
      end

      ST_MUL1: begin
        a2_d    = aa * aa;
        b2_d    = bb * bb;
        state_d = ST_MUL2;
      end

      ST_MUL2: begin
        b2s_d   = DW'(b2s_init);
        a2s_d   = DW'(a2_q);
        delta_d = DW'(2) - (DW'(bb) <<< 1);
        xi_d    = '0;
        yi_d    = (XIW + 1)'(aa);
        xp_d    = rx_q[XW-1:0];
        xm_d    = rx_q[XW-1:0];
        sx_d    = rx_q[XW-1:0];
        yp_d    = rp_q[YW-1:0];
        ym_d    = rm_q[YW-1:0];
        cnt_d   = '0;
        phase_d = 1'b0;
        state_d = ST_SPAN;
      end

      ST_SPAN: begin
        mem_we = 1'b1;
        ax     = sx_q;
        ay     = phase_q ? yp_q : ym_q;
        if (cnt_q == {xi_q, 1'b0}) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            cnt_d   = '0;
            sx_d    = xm_q;
          end else begin
            state_d = ST_STEP;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
          sx_d  = inc_x(sx_q);
        end
      end

      ST_EDGE: begin
        mem_we    = 1'b1;
        mem_wdata = edge_color;
        unique case (ecnt_q)
          2'd0: begin ax = xp_q; ay = yp_q; end
          2'd1: begin ax = xm_q; ay = ym_q; end
          2'd2: begin ax = xp_q; ay = ym_q; end
          default: begin ax = xm_q; ay = yp_q; end
        endcase
        ecnt_d = ecnt_q + 1'b1;
        if (ecnt_q == 2'd3) begin
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (ydec && yi_q == '0) begin
          done_d            = 1'b1;
          res_d.pixel_value = '0;
          res_d.drew_shape  = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          // advance the decision variable
          if (step_diag) begin
            a2s_d   = a2s_inc;
            b2s_d   = b2s_dec;
            delta_d = delta_q + a2s_inc - b2s_dec;
          end else if (step_horiz) begin
            a2s_d   = a2s_inc;
            delta_d = delta_q + a2s_inc;
          end else begin
            b2s_d   = b2s_dec;
            delta_d = delta_q - b2s_dec;
          end
          if (xinc) begin
            xi_d = xi_q + 1'b1;
            xp_d = inc_x(xp_q);
            xm_d = dec_x(xm_q);
            sx_d = dec_x(xm_q);
          end else begin
            sx_d = xm_q;
          end
          if (ydec) begin
            yi_d = yi_q - 1'b1;
            yp_d = dec_y(yp_q);
            ym_d = inc_y(ym_q);
          end
          cnt_d   = '0;
          phase_d = 1'b0;
          ecnt_d  = '0;
          state_d = ydec ? ST_SPAN : ST_EDGE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (state_q == ST_CLEAR) begin
      mem_addr = clr_q;
    end else begin
      mem_addr = AW'(ay) * AW'(GRID_WIDTH) + AW'(ax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    item_q  <= item_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    rp_q    <= rp_d;
    rm_q    <= rm_d;
    xp_q    <= xp_d;
    xm_q    <= xm_d;
    sx_q    <= sx_d;
    yp_q    <= yp_d;
    ym_q    <= ym_d;
    xi_q    <= xi_d;
    yi_q    <= yi_d;
    cnt_q   <= cnt_d;
    phase_q <= phase_d;
    ecnt_q  <= ecnt_d;
    a2_q    <= a2_d;
    b2_q    <= b2_d;
    a2s_q   <= a2s_d;
    b2s_q   <= b2s_d;
    delta_q <= delta_d;
  end

  tfep_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == ST_IDLE)
    else $error("result strobe while a command is still in progress");

  a_clear_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> mem_we && mem_wdata == CLEAR_COLOR && !done_o)
    else $error("clearing pass not writing the reset color");

  a_wrapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL1 |-> in_range(rx_q, MOD_X) && in_range(rp_q, MOD_Y) &&
                           in_range(rm_q, MOD_Y))
    else $error("walk started from coordinates off the grid");

  a_span_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SPAN |-> cnt_q <= {xi_q, 1'b0})
    else $error("span ran past its length");

endmodule

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tfep_pkg::*;

  localparam int GRID_H = 256;
  localparam int GRID_W = 2 * GRID_H;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS = 375;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    tfep_in_t  cmd;
    bit        typed;
    tfep_out_t result;
  } stim_row_t;

  typedef struct {
    int x;
    int y;
    int reach;
  } shape_spot_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cmd_start;
  tfep_in_t  cmd_item;
  logic      busy;
  logic      done;
  tfep_out_t result;

  // typed-in expectation that travels with the command being offered
  bit        cmd_typed;
  tfep_out_t cmd_typed_result;

  bit [7:0]    canvas [GRID_H][GRID_W];
  tfep_out_t   pending_results [$];
  shape_spot_t recent_shapes [$];
  stim_row_t   directed_rows [$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned report_count;
  int unsigned results_checked;
  int unsigned shapes_seen;
  int unsigned op_count [4];

  toroidal_filled_ellipse_painter_core #(
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (cmd_start),
    .item_i  (cmd_item),
    .busy    (busy),
    .done_o  (done),
    .result_o(result)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint wrap_mod(longint v, longint m);
    longint r;
    r = v % m;
    if (r < 0) begin
      r += m;
    end
    return r;
  endfunction

  function automatic void plot(longint x, longint y, logic [7:0] color);
    canvas[wrap_mod(y, GRID_H)][wrap_mod(x, GRID_W)] = color;
  endfunction

  // Bresenham fill: spans on a new row, rim pixels while staying on a row
  function automatic bit paint_walk(longint xs, longint ys, longint bb, longint aa,
                                    logic [7:0] color);
    longint xi, yi, prev_row, a2, b2, a2s, b2s, delta, n, k;
    bit have_prev;
    logic [7:0] rim;
    if (aa == 0 || bb == 0) begin
      return 1'b0;
    end
    xi = 0;
    yi = aa;
    prev_row = 0;
    have_prev = 1'b0;
    a2 = aa * aa;
    b2 = bb * bb;
    a2s = a2;
    b2s = b2 * (2 * aa + 1);
    delta = 2 * (1 - bb);
    rim = color + EDGE_OFFSET;
    while (yi >= 0) begin
      if (!have_prev || prev_row != yi) begin
        n = 2 * xi + 1;
        for (k = 0; k < n; k++) begin
          plot(xs - xi + k, ys - yi, color);
          plot(xs - xi + k, ys + yi, color);
        end
      end else begin
        plot(xs + xi, ys + yi, rim);
        plot(xs - xi, ys - yi, rim);
        plot(xs + xi, ys - yi, rim);
        plot(xs - xi, ys + yi, rim);
      end
      prev_row = yi;
      have_prev = 1'b1;
      if (delta < 0) begin
        if (2 * delta + b2s > 0) begin
          xi++;
          yi--;
          a2s += 2 * a2;
          b2s -= 2 * b2;
          delta += a2s - b2s;
        end else begin
          xi++;
          a2s += 2 * a2;
          delta += a2s;
        end
      end else if (delta == 0 || 2 * delta - a2s <= 0) begin
        xi++;
        yi--;
        a2s += 2 * a2;
        b2s -= 2 * b2;
        delta += a2s - b2s;
      end else begin
        yi--;
        b2s -= 2 * b2;
        delta -= b2s;
      end
    end
    return 1'b1;
  endfunction

  // Update the canvas for one command and return the result it must produce
  function automatic tfep_out_t apply_command(tfep_in_t c);
    tfep_out_t r;
    longint cx, cy, va, ha;
    cx = longint'(c.center_x);
    cy = longint'(c.center_y);
    va = longint'(c.vertical_axis);
    ha = longint'(c.horizontal_axis);
    r = '0;
    case (c.op)
      OP_CRATER: begin
        if (va <= 1) begin
          plot(cx, cy, c.paint_color);
        end
        r.drew_shape = paint_walk(cx, cy, va, va, c.paint_color);
      end
      OP_ELLIPSE: begin
        r.drew_shape = paint_walk(cx, cy, ha, va, c.paint_color);
      end
      OP_READ: begin
        r.pixel_value = canvas[wrap_mod(cy, GRID_H)][wrap_mod(cx, GRID_W)];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t step_row(logic [OP_W-1:0] op, int cx, int cy, int va,
                                         int ha, int color, bit typed, int pix, bit drew);
    stim_row_t s;
    s.cmd.op = op;
    s.cmd.center_x = CX_W'(cx);
    s.cmd.center_y = CY_W'(cy);
    s.cmd.vertical_axis = AXIS_W'(va);
    s.cmd.horizontal_axis = AXIS_W'(ha);
    s.cmd.paint_color = COLOR_W'(color);
    s.typed = typed;
    s.result.pixel_value = COLOR_W'(pix);
    s.result.drew_shape = drew;
    return s;
  endfunction

  function automatic tfep_in_t random_cmd();
    tfep_in_t c;
    shape_spot_t spot;
    int pick, reach;
    c.center_x = CX_W'($urandom_range(GRID_W - 1));
    c.center_y = CY_W'($urandom_range(GRID_H - 1));
    c.vertical_axis = AXIS_W'($urandom_range(256));
    c.horizontal_axis = AXIS_W'($urandom_range(256));
    c.paint_color = COLOR_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 25) begin
      c.op = OP_CRATER;
      c.vertical_axis = AXIS_W'(($urandom_range(9) == 0) ? $urandom_range(24, 7) :
                                                          $urandom_range(6));
    end else if (pick < 60) begin
      c.op = OP_ELLIPSE;
      pick = $urandom_range(99);
      if (pick < 80) begin
        c.vertical_axis = AXIS_W'($urandom_range(8));
        c.horizontal_axis = AXIS_W'($urandom_range(8));
      end else if (pick < 92) begin
        // long thin shape: one axis over the full range, the other tiny
        if ($urandom_range(1)) begin
          c.vertical_axis = AXIS_W'($urandom_range(256));
          c.horizontal_axis = AXIS_W'($urandom_range(3));
        end else begin
          c.vertical_axis = AXIS_W'($urandom_range(3));
          c.horizontal_axis = AXIS_W'($urandom_range(256));
        end
      end else begin
        c.vertical_axis = AXIS_W'($urandom_range(24));
        c.horizontal_axis = AXIS_W'($urandom_range(24));
      end
    end else if (pick < 98) begin
      c.op = OP_READ;
      // mostly probe around something recently painted
      if (recent_shapes.size() != 0 && $urandom_range(9) < 7) begin
        spot = recent_shapes[$urandom_range(recent_shapes.size() - 1)];
        reach = spot.reach;
        c.center_x = CX_W'(wrap_mod(longint'(spot.x + int'($urandom_range(2 * reach)) - reach),
                                    longint'(GRID_W)));
        c.center_y = CY_W'(wrap_mod(longint'(spot.y + int'($urandom_range(2 * reach)) - reach),
                                    longint'(GRID_H)));
      end
    end else begin
      c.op = OP_UNUSED;
    end
    if (c.op == OP_CRATER || c.op == OP_ELLIPSE) begin
      spot.x = int'(c.center_x);
      spot.y = int'(c.center_y);
      spot.reach = int'((c.op == OP_CRATER || c.vertical_axis > c.horizontal_axis) ?
                        c.vertical_axis : c.horizontal_axis) + 1;
      recent_shapes.push_back(spot);
      if (recent_shapes.size() > 8) begin
        void'(recent_shapes.pop_front());
      end
    end
    return c;
  endfunction

  task automatic issue(input tfep_in_t cmd, input bit typed, input tfep_out_t typed_result,
                       input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      @(negedge clk_i);
      cmd_start = 1'b0;
    end
    @(negedge clk_i);
    cmd_start = 1'b1;
    cmd_item = cmd;
    cmd_typed = typed;
    cmd_typed_result = typed_result;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    cmd_start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Check results and record predictions for every accepted command
  always @(posedge clk_i) begin
    tfep_out_t got, want;
    if (rst_ni) begin
      if (done) begin
        got = result;
        if (pending_results.size() == 0) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("unexpected result pixel=%0d drew=%0d at cycle %0d",
                     got.pixel_value, got.drew_shape, cycle_count);
          end
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.drew_shape === 1'b1) begin
            shapes_seen++;
          end
          if (got.pixel_value !== want.pixel_value || got.drew_shape !== want.drew_shape) begin
            error_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("mismatch at cycle %0d: pixel exp %0d got %0d, drew exp %0d got %0d",
                       cycle_count, want.pixel_value, got.pixel_value,
                       want.drew_shape, got.drew_shape);
            end
          end
        end
      end
      if (cmd_start && !busy) begin
        want = apply_command(cmd_item);
        if (cmd_typed) begin
          want = cmd_typed_result;
        end
        pending_results.push_back(want);
        op_count[cmd_item.op]++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    int phase_idle [4];
    tfep_out_t none;
    cmd_start = 1'b0;
    cmd_item = '0;
    cmd_typed = 1'b0;
    cmd_typed_result = '0;
    rst_ni = 1'b0;
    none = '0;
    phase_idle = '{0, 59, 0, 13};
    for (int y = 0; y < GRID_H; y++) begin
      for (int x = 0; x < GRID_W; x++) begin
        canvas[y][x] = CLEAR_COLOR;
      end
    end

    directed_rows.push_back(step_row(OP_READ,      0,   0,   0,   0,   0, 1, 255, 0));
    directed_rows.push_back(step_row(OP_READ,    511, 255,   0,   0,   0, 1, 255, 0));
    directed_rows.push_back(step_row(OP_UNUSED,  511, 255, 256, 256, 255, 1,   0, 0));
    directed_rows.push_back(step_row(OP_ELLIPSE,  40,  40,   0,   5,   3, 1,   0, 0));
    directed_rows.push_back(step_row(OP_ELLIPSE,  40,  40,   5,   0,   3, 1,   0, 0));
    directed_rows.push_back(step_row(OP_READ,     40,  40,   0,   0,   0, 1, 255, 0));
    directed_rows.push_back(step_row(OP_CRATER,  100,  50,   0,   0,   9, 1,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    100,  50,   0,   0,   0, 1,   9, 0));
    directed_rows.push_back(step_row(OP_CRATER,    0,   0,   1,   0, 254, 1,   0, 1));
    directed_rows.push_back(step_row(OP_READ,      0,   0,   0,   0,   0, 1, 254, 0));
    directed_rows.push_back(step_row(OP_READ,    511,   0,   0,   0,   0, 1, 254, 0));
    directed_rows.push_back(step_row(OP_READ,      0, 255,   0,   0,   0, 1, 254, 0));
    directed_rows.push_back(step_row(OP_CRATER,    0,   0,   1,   0, 255, 1,   0, 1));
    directed_rows.push_back(step_row(OP_READ,      0,   1,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_ELLIPSE, 300, 200,   3,   7, 254, 0,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    307, 200,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    293, 200,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    300, 203,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_ELLIPSE, 511, 255, 256,   1, 128, 0,   0, 0));
    directed_rows.push_back(step_row(OP_ELLIPSE,   0,   0,   1, 256, 253, 0,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    256,   0,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_ELLIPSE, 255, 128, 256, 256,   0, 1,   0, 1));
    directed_rows.push_back(step_row(OP_READ,    255, 128,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    100, 200,   0,   0,   0, 0,   0, 0));
    directed_rows.push_back(step_row(OP_CRATER,  510,   3,  24,   0,  77, 0,   0, 0));
    directed_rows.push_back(step_row(OP_READ,    511,   0,   0,   0,   0, 0,   0, 0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].result, 0);
    end

    foreach (phase_idle[p]) begin
      // let the painter go fully idle between phases
      hold_until_drained();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(random_cmd(), 1'b0, none, phase_idle[p]);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0d results never arrived", pending_results.size());
    end
    $display("covered %0d craters, %0d ellipses, %0d reads, %0d unused-op commands",
             op_count[OP_CRATER], op_count[OP_ELLIPSE], op_count[OP_READ],
             op_count[OP_UNUSED]);
    $display("checked %0d results (%0d shapes drawn) in %0d cycles, %0d errors",
             results_checked, shapes_seen, cycle_count, error_count);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
